// ----- rtl/ftss_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftss_pkg: shared types and constants
// Operation and source codes, register indexes and the beat structs used
// across the freshest time source selector.
// ----------------------------------------------------------------------------
package ftss_pkg;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned AGE_W  = 12;
  localparam int unsigned IDX_W  = 2;

  localparam logic [AGE_W-1:0] FRESH_AGE_RST = 12'd4;
  localparam logic [AGE_W-1:0] STALE_AGE_RST = 12'd60;

  typedef enum logic [2:0] {
    OP_RTC_SYNC = 3'd0,
    OP_GPS_SYNC = 3'd1,
    OP_TICK     = 3'd2,
    OP_QUERY    = 3'd3,
    OP_CLEAR    = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    SRC_NONE = 2'd0,
    SRC_GPS  = 2'd1,
    SRC_RTC  = 2'd2,
    SRC_APP  = 2'd3
  } src_t;

  typedef enum logic [IDX_W-1:0] {
    REG_FRESH_AGE = 2'd0,
    REG_STALE_AGE = 2'd1
  } cfg_reg_t;

  // One input beat as held in the input register
  typedef struct packed {
    logic [2:0]        operation;
    logic [TIME_W-1:0] time_value;
    logic [TIME_W-1:0] now_seconds;
  } item_t;

  // Snapshot of all three sources
  typedef struct packed {
    logic [TIME_W-1:0] gps_time;
    logic [TIME_W-1:0] gps_stamp;
    logic [TIME_W-1:0] rtc_time;
    logic [TIME_W-1:0] rtc_stamp;
    logic [TIME_W-1:0] app_time;
    logic [TIME_W-1:0] app_stamp;
  } src_state_t;

endpackage

// ----- rtl/ftss_in_reg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftss_in_reg: input register
// Captures one input beat and holds it until the next stage takes it.
// ----------------------------------------------------------------------------
module ftss_in_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  ftss_pkg::item_t in_item,
  input  logic          advance,
  output logic          item_valid,
  output ftss_pkg::item_t item
);

  logic            valid_r;
  logic            valid_nxt;
  ftss_pkg::item_t item_r;

  // Stall only while a held beat cannot move on
  assign in_stall = valid_r && !advance;

  always_comb begin
    valid_nxt = valid_r;
    if (!in_stall) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ----- rtl/ftss_sources.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftss_sources: source registers
// Holds time and stamp for GPS, RTC and the application clock and applies
// sync, tick and clear beats.
// ----------------------------------------------------------------------------
module ftss_sources (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  ftss_pkg::item_t      item,
  output ftss_pkg::src_state_t state
);

  ftss_pkg::src_state_t state_r;
  ftss_pkg::src_state_t state_nxt;
  logic                 gps_seen;

  assign gps_seen = (state_r.gps_stamp != '0);

  always_comb begin
    state_nxt = state_r;
    if (fire) begin
      case (ftss_pkg::op_t'(item.operation))
        ftss_pkg::OP_RTC_SYNC, ftss_pkg::OP_GPS_SYNC: begin
          // Seed the application clock until GPS has been seen
          if (!gps_seen) begin
            state_nxt.app_time  = item.time_value;
            state_nxt.app_stamp = item.now_seconds;
          end
          if (ftss_pkg::op_t'(item.operation) == ftss_pkg::OP_GPS_SYNC) begin
            state_nxt.gps_time  = item.time_value;
            state_nxt.gps_stamp = item.now_seconds;
          end else begin
            state_nxt.rtc_time  = item.time_value;
            state_nxt.rtc_stamp = item.now_seconds;
          end
        end
        ftss_pkg::OP_TICK: begin
          if (gps_seen) begin
            state_nxt.app_time  = state_r.app_time + 32'd1;
            state_nxt.app_stamp = item.now_seconds;
          end
        end
        ftss_pkg::OP_CLEAR: begin
          state_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign state = state_r;

endmodule

// ----- rtl/ftss_selector.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftss_selector: source choice
// Computes the three ages and picks the time to report for a query.
// ----------------------------------------------------------------------------
module ftss_selector (
  input  ftss_pkg::src_state_t                 state,
  input  logic [ftss_pkg::TIME_W-1:0]          now_seconds,
  input  logic [ftss_pkg::AGE_W-1:0]           fresh_age,
  input  logic [ftss_pkg::AGE_W-1:0]           stale_age,
  output logic [ftss_pkg::TIME_W-1:0]          chosen_time,
  output ftss_pkg::src_t                       source
);

  logic [ftss_pkg::TIME_W-1:0] stale_plus;
  logic [ftss_pkg::TIME_W-1:0] fresh_w;
  logic [ftss_pkg::TIME_W-1:0] stale_w;
  logic [ftss_pkg::TIME_W-1:0] a_gps;
  logic [ftss_pkg::TIME_W-1:0] a_rtc;
  logic [ftss_pkg::TIME_W-1:0] a_app;
  logic                        any_set;

  assign fresh_w    = {{(ftss_pkg::TIME_W-ftss_pkg::AGE_W){1'b0}}, fresh_age};
  assign stale_w    = {{(ftss_pkg::TIME_W-ftss_pkg::AGE_W){1'b0}}, stale_age};
  assign stale_plus = stale_w + 32'd1;

  // A stamp in the future reads as just past stale
  assign a_gps = (now_seconds >= state.gps_stamp) ? now_seconds - state.gps_stamp
                                                  : stale_plus;
  assign a_rtc = (now_seconds >= state.rtc_stamp) ? now_seconds - state.rtc_stamp
                                                  : stale_plus;
  assign a_app = (now_seconds >= state.app_stamp) ? now_seconds - state.app_stamp
                                                  : stale_plus;

  assign any_set = (state.gps_stamp != '0) || (state.rtc_stamp != '0) ||
                   (state.app_stamp != '0);

  always_comb begin
    source = ftss_pkg::SRC_NONE;
    if (any_set) begin
      if (a_gps < fresh_w) begin
        source = ftss_pkg::SRC_GPS;
      end else if (a_rtc < fresh_w) begin
        source = ftss_pkg::SRC_RTC;
      end else if (a_app < fresh_w) begin
        source = ftss_pkg::SRC_APP;
      end else if (a_gps > stale_w && a_rtc > stale_w && a_app > stale_w) begin
        source = ftss_pkg::SRC_NONE;
      end else if (a_gps < a_rtc) begin
        source = (a_gps < a_app) ? ftss_pkg::SRC_GPS : ftss_pkg::SRC_APP;
      end else begin
        source = (a_rtc < a_app) ? ftss_pkg::SRC_RTC : ftss_pkg::SRC_APP;
      end
    end
  end

  always_comb begin
    case (source)
      ftss_pkg::SRC_GPS: chosen_time = state.gps_time;
      ftss_pkg::SRC_RTC: chosen_time = state.rtc_time;
      ftss_pkg::SRC_APP: chosen_time = state.app_time;
      default:           chosen_time = '0;
    endcase
  end

endmodule

// ----- rtl/freshest_time_source_selector_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// freshest_time_source_selector_unit: top level
// Tracks GPS, RTC and application clock time and answers queries with the
// freshest usable source.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (in_operation, in_time_value, in_now_seconds) are taken when
//   in_valid is high and in_stall is low. Sync, tick and clear beats update
//   the source registers and give no result; a query gives one result beat
//   (out_chosen_time, out_source), taken when out_valid is high and
//   out_stall is low. Codes 5 to 7 are dropped.
//   A query beat passes from the input register into the result register,
//   where its result shows on the outputs. Throughput: one beat per cycle
//   while in_stall is low, set by the single pass between those two
//   registers; a new beat is taken while a result waits.
//   A stalled result holds; in_stall rises only when a query sits in the
//   input register behind a held result.
//   Reset clears all sources (stamps read as never set), sets fresh_age to
//   4 and stale_age to 60 and empties both registers. Registers are written
//   through cfg_valid/cfg_ready (always ready); unknown indexes are ignored.
// ----------------------------------------------------------------------------
module freshest_time_source_selector_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [2:0]                      in_operation,
  input  logic [ftss_pkg::TIME_W-1:0]     in_time_value,
  input  logic [ftss_pkg::TIME_W-1:0]     in_now_seconds,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ftss_pkg::TIME_W-1:0]     out_chosen_time,
  output logic [1:0]                      out_source,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ftss_pkg::IDX_W-1:0]      cfg_index,
  input  logic [ftss_pkg::AGE_W-1:0]      cfg_wdata
);

  ftss_pkg::item_t              in_item;
  ftss_pkg::item_t              item;
  logic                         item_valid;
  logic                         is_query;
  logic                         advance;
  logic                         fire;
  ftss_pkg::src_state_t         state;
  logic [ftss_pkg::TIME_W-1:0]  sel_time;
  ftss_pkg::src_t               sel_source;

  logic [ftss_pkg::AGE_W-1:0]   fresh_age_r;
  logic [ftss_pkg::AGE_W-1:0]   stale_age_r;
  logic                         out_valid_r;
  logic                         out_valid_nxt;
  logic [ftss_pkg::TIME_W-1:0]  out_time_r;
  logic [1:0]                   out_source_r;

  assign in_item.operation   = in_operation;
  assign in_item.time_value  = in_time_value;
  assign in_item.now_seconds = in_now_seconds;

  assign is_query = (ftss_pkg::op_t'(item.operation) == ftss_pkg::OP_QUERY);
  // Only a query needs room in the result register
  assign advance  = !is_query || !out_valid_r || !out_stall;
  assign fire     = item_valid && advance;

  ftss_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  ftss_sources u_sources (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item),
    .state (state)
  );

  ftss_selector u_selector (
    .state       (state),
    .now_seconds (item.now_seconds),
    .fresh_age   (fresh_age_r),
    .stale_age   (stale_age_r),
    .chosen_time (sel_time),
    .source      (sel_source)
  );

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fresh_age_r <= ftss_pkg::FRESH_AGE_RST;
      stale_age_r <= ftss_pkg::STALE_AGE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (ftss_pkg::cfg_reg_t'(cfg_index))
        ftss_pkg::REG_FRESH_AGE: fresh_age_r <= cfg_wdata;
        ftss_pkg::REG_STALE_AGE: stale_age_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire && is_query) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && is_query) begin
      out_time_r   <= sel_time;
      out_source_r <= sel_source;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_chosen_time = out_time_r;
  assign out_source      = out_source_r;

endmodule
